// ----- hdl/idtdn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idtdn_pkg
// Constants and calendar helpers for the ISO date text to day number block.
// ----------------------------------------------------------------------------
package idtdn_pkg;

  localparam int unsigned CharW  = 16;
  localparam int unsigned PosW   = 4;
  localparam int unsigned AccW   = 7;
  localparam int unsigned DaysW  = 23;
  localparam int unsigned SumW   = 22;

  // Character codes.
  localparam logic [CharW-1:0] CH_DASH = 16'h002D;
  localparam logic [CharW-1:0] CH_ZERO = 16'h0030;
  localparam logic [CharW-1:0] CH_NINE = 16'h0039;

  // Character positions inside YYYY-MM-DD.
  localparam logic [PosW-1:0] POS_YH0   = 4'd0;
  localparam logic [PosW-1:0] POS_YH1   = 4'd1;
  localparam logic [PosW-1:0] POS_YL0   = 4'd2;
  localparam logic [PosW-1:0] POS_YL1   = 4'd3;
  localparam logic [PosW-1:0] POS_DASH1 = 4'd4;
  localparam logic [PosW-1:0] POS_MON0  = 4'd5;
  localparam logic [PosW-1:0] POS_MON1  = 4'd6;
  localparam logic [PosW-1:0] POS_DASH2 = 4'd7;
  localparam logic [PosW-1:0] POS_DAY0  = 4'd8;
  localparam logic [PosW-1:0] POS_DAY1  = 4'd9;
  localparam logic [PosW-1:0] DATE_LEN  = 4'd10;
  localparam logic [PosW-1:0] POS_SAT   = 4'd11;

  // Months.
  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  // Day count terms. The year is taken as starting in March and moved up by
  // four centuries so that every term stays non-negative.
  localparam logic [SumW-1:0]         DAYS_PER_CENTURY = 22'd36524;
  localparam logic [SumW-1:0]         DAYS_PER_YEAR    = 22'd365;
  localparam logic signed [DaysW-1:0] EPOCH_BIAS       = 23'sd865566;
  localparam logic [AccW-1:0]         CENTURY_SHIFT    = 7'd4;
  localparam logic [AccW-1:0]         LAST_YEAR_OF_CENT = 7'd99;

  localparam logic signed [DaysW-1:0] DAY_MIN = -23'sd719528;
  localparam logic signed [DaysW-1:0] DAY_MAX = 23'sd2932896;

  // Length of a month in days.
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      MON_FEB:                             len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV:  len = 5'd30;
      default:                             len = 5'd31;
    endcase
    return len;
  endfunction

  // Days from the first of March to the first of the month.
  function automatic logic [8:0] month_offset(input logic [3:0] mon);
    logic [8:0] off;
    case (mon)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  // Decimal shift-in of one digit, kept to the accumulator width.
  function automatic logic [AccW-1:0] mul10_add(input logic [AccW-1:0] acc,
                                                input logic [3:0] dig);
    logic [AccW+2:0] t;
    t = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{(AccW-1){1'b0}}, dig};
    return t[AccW-1:0];
  endfunction

endpackage

// ----- hdl/iso_date_text_to_day_number.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso_date_text_to_day_number
// Parses YYYY-MM-DD text, one character word per cycle while in_ready is high, into a day number.
// ----------------------------------------------------------------------------
//  channel | ports                                   | moves
//  --------+-----------------------------------------+-----------------------
//  in      | in_valid, in_ready, in_char_code,       | one character word
//          | in_end_of_text                          |
//  out     | out_valid, out_ready, out_date_valid,   | one result word per
//          | out_epoch_day                           | text, on its last char
//
//  One character word is taken per cycle while in_ready is high. A result
//  reaches the output register through stage A: the digits are collected as
//  the character goes in and registered in stage A, and the calendar check
//  and day count adders work between stage A and the output register.
//  rst_n is synchronous and active low; it empties both stages and clears the
//  digit collectors.
//  A stall at out_ready backs up through the two stages to in_ready.
// ----------------------------------------------------------------------------
module iso_date_text_to_day_number (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_char_code,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_date_valid,
  output logic signed [22:0] out_epoch_day
);

  // Collector state.
  logic [idtdn_pkg::PosW-1:0] pos_r, pos_nxt;
  logic [idtdn_pkg::AccW-1:0] yh_r, yh_nxt, yl_r, yl_nxt;
  logic [idtdn_pkg::AccW-1:0] mon_r, mon_nxt, day_r, day_nxt;
  logic                       err_r, err_nxt;

  // Stage A: one complete text.
  logic                       a_vld_r;
  logic [idtdn_pkg::AccW-1:0] a_yh_r, a_yl_r, a_mon_r, a_day_r;
  logic                       a_fmt_ok_r;

  // Output register.
  logic                       out_vld_r;
  logic                       out_date_valid_r;
  logic signed [22:0]         out_epoch_day_r;

  logic       b_ready, a_ready, in_acc;
  logic       is_digit, is_dash, in_date, dash_pos, char_bad;
  logic [3:0] dig;
  logic       fmt_ok;

  assign b_ready = !out_vld_r || out_ready;
  assign a_ready = !a_vld_r || b_ready;
  assign in_ready = a_ready;
  assign in_acc = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Character check and digit collection.
  // --------------------------------------------------------------------------
  always_comb begin
    is_digit = (in_char_code >= idtdn_pkg::CH_ZERO) && (in_char_code <= idtdn_pkg::CH_NINE);
    is_dash  = in_char_code == idtdn_pkg::CH_DASH;
    dig      = in_char_code[3:0];
    in_date  = pos_r < idtdn_pkg::DATE_LEN;
    dash_pos = (pos_r == idtdn_pkg::POS_DASH1) || (pos_r == idtdn_pkg::POS_DASH2);
    char_bad = in_date && (dash_pos ? !is_dash : !is_digit);
    err_nxt  = err_r || char_bad;
    pos_nxt  = (pos_r < idtdn_pkg::POS_SAT) ? pos_r + 4'd1 : pos_r;
    // The last character completes a ten-character text when nine came before.
    fmt_ok   = !err_nxt && (pos_r == idtdn_pkg::POS_DAY1);

    yh_nxt  = yh_r;
    yl_nxt  = yl_r;
    mon_nxt = mon_r;
    day_nxt = day_r;
    if (is_digit) begin
      case (pos_r)
        idtdn_pkg::POS_YH0, idtdn_pkg::POS_YH1:   yh_nxt  = idtdn_pkg::mul10_add(yh_r, dig);
        idtdn_pkg::POS_YL0, idtdn_pkg::POS_YL1:   yl_nxt  = idtdn_pkg::mul10_add(yl_r, dig);
        idtdn_pkg::POS_MON0, idtdn_pkg::POS_MON1: mon_nxt = idtdn_pkg::mul10_add(mon_r, dig);
        idtdn_pkg::POS_DAY0, idtdn_pkg::POS_DAY1: day_nxt = idtdn_pkg::mul10_add(day_r, dig);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      yh_r  <= '0;
      yl_r  <= '0;
      mon_r <= '0;
      day_r <= '0;
      err_r <= 1'b0;
    end else if (in_acc) begin
      if (in_end_of_text) begin
        pos_r <= '0;
        yh_r  <= '0;
        yl_r  <= '0;
        mon_r <= '0;
        day_r <= '0;
        err_r <= 1'b0;
      end else begin
        pos_r <= pos_nxt;
        yh_r  <= yh_nxt;
        yl_r  <= yl_nxt;
        mon_r <= mon_nxt;
        day_r <= day_nxt;
        err_r <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_ready) begin
      a_vld_r <= in_valid && in_end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_yh_r     <= yh_nxt;
      a_yl_r     <= yl_nxt;
      a_mon_r    <= mon_nxt;
      a_day_r    <= day_nxt;
      a_fmt_ok_r <= fmt_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Calendar check and day count.
  // --------------------------------------------------------------------------
  logic                       jan_feb, yl_zero, borrow, leap, date_ok;
  logic [idtdn_pkg::AccW-1:0] r_adj, c_adj;
  logic [4:0]                 mlen;
  logic [idtdn_pkg::SumW-1:0] sum_pos;
  logic signed [22:0]         days;

  always_comb begin
    jan_feb = (a_mon_r == {3'b000, idtdn_pkg::MON_JAN}) ||
              (a_mon_r == {3'b000, idtdn_pkg::MON_FEB});
    yl_zero = a_yl_r == '0;
    // January and February count with the previous year.
    borrow  = jan_feb && yl_zero;
    if (!jan_feb) begin
      r_adj = a_yl_r;
    end else if (yl_zero) begin
      r_adj = idtdn_pkg::LAST_YEAR_OF_CENT;
    end else begin
      r_adj = a_yl_r - 7'd1;
    end
    c_adj = a_yh_r + idtdn_pkg::CENTURY_SHIFT - {6'b000000, borrow};

    leap    = yl_zero ? (a_yh_r[1:0] == 2'b00) : (a_yl_r[1:0] == 2'b00);
    mlen    = idtdn_pkg::month_len(a_mon_r[3:0], leap);
    date_ok = a_fmt_ok_r &&
              (a_mon_r >= {3'b000, idtdn_pkg::MON_JAN}) &&
              (a_mon_r <= {3'b000, idtdn_pkg::MON_DEC}) &&
              (a_day_r != '0) && (a_day_r <= {2'b00, mlen});

    sum_pos = 22'(c_adj) * idtdn_pkg::DAYS_PER_CENTURY + 22'(c_adj[6:2]) +
              22'(r_adj) * idtdn_pkg::DAYS_PER_YEAR + 22'(r_adj[6:2]) +
              22'(idtdn_pkg::month_offset(a_mon_r[3:0])) + 22'(a_day_r);
    days    = signed'({1'b0, sum_pos}) - idtdn_pkg::EPOCH_BIAS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (b_ready) begin
      out_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      out_date_valid_r <= date_ok;
      out_epoch_day_r  <= date_ok ? days : '0;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_date_valid = out_date_valid_r;
  assign out_epoch_day  = out_epoch_day_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= idtdn_pkg::POS_SAT)
    else $error("character position ran past saturation");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_text |=> pos_r == '0 && !err_r && a_vld_r)
    else $error("last character did not hand off and restart collection");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_date_valid_r |-> out_epoch_day_r == '0)
    else $error("invalid date carries a nonzero day number");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_date_valid_r |->
      out_epoch_day_r >= idtdn_pkg::DAY_MIN && out_epoch_day_r <= idtdn_pkg::DAY_MAX)
    else $error("day number out of calendar range");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && !b_ready |=> a_vld_r)
    else $error("pending text lost while output stalled");

endmodule

// ----- tb/tb_iso_date_text_to_day_number.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iso_date_text_to_day_number
// Self-checking bench: feeds date texts one character word at a time, with
// random gaps on the input and random stalls on the result side, and checks
// every result word against a local calendar predictor.
// ----------------------------------------------------------------------------
module tb_iso_date_text_to_day_number;

  typedef struct {
    logic [15:0] code;
    logic        last;
    int          gap;
  } char_item_t;

  typedef struct packed {
    logic              ok;
    logic signed [22:0] day;
  } date_result_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [15:0] in_char_code   = '0;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic        out_date_valid;
  logic signed [22:0] out_epoch_day;

  char_item_t   pending_chars[$];
  date_result_t expected_dates[$];
  logic [15:0]  text_buf[$];

  // Predictor copy of the parser state.
  logic [3:0]  text_pos     = '0;
  logic [13:0] year_digits  = '0;
  logic [6:0]  month_digits = '0;
  logic [6:0]  day_digits   = '0;
  logic        layout_bad   = 1'b0;

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  logic hold_off  = 1'b0;
  int   chars_taken    = 0;
  int   results_seen   = 0;
  int   mismatch_count = 0;
  int   total_chars    = 0;
  int   calm_left      = 0;
  int   gap_left       = 0;
  bit   gap_loaded     = 1'b0;
  int   stall_left     = 0;
  int   rx_calm_left   = 0;

  iso_date_text_to_day_number i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_date_valid (out_date_valid),
    .out_epoch_day  (out_epoch_day)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int days_in_month(int y, int m);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (m == idtdn_pkg::MON_FEB) return leap ? 29 : 28;
    if (m == idtdn_pkg::MON_APR || m == idtdn_pkg::MON_JUN ||
        m == idtdn_pkg::MON_SEP || m == idtdn_pkg::MON_NOV) return 30;
    return 31;
  endfunction

  // Civil date to day count; years run March to February and are moved up by
  // one 400-year cycle so that nothing goes negative.
  function automatic int days_since_epoch(int y, int m, int d);
    int ys, cycle, yoc, mar_month, day_of_year, day_of_cycle;
    ys           = y + 400 - ((m <= 2) ? 1 : 0);
    cycle        = ys / 400;
    yoc          = ys - cycle * 400;
    mar_month    = (m + 9) % 12;
    day_of_year  = (153 * mar_month + 2) / 5 + d - 1;
    day_of_cycle = yoc * 365 + yoc / 4 - yoc / 100 + day_of_year;
    return cycle * 146097 + day_of_cycle - 719468 - 146097;
  endfunction

  task automatic parse_char(input logic [15:0] ch, input logic last);
    logic [3:0]   dig;
    date_result_t res;
    bit           ok;
    if (text_pos < idtdn_pkg::DATE_LEN) begin
      if (text_pos == idtdn_pkg::POS_DASH1 || text_pos == idtdn_pkg::POS_DASH2) begin
        if (ch != idtdn_pkg::CH_DASH) layout_bad = 1'b1;
      end else if (ch < idtdn_pkg::CH_ZERO || ch > idtdn_pkg::CH_NINE) begin
        layout_bad = 1'b1;
      end else begin
        dig = 4'(ch - idtdn_pkg::CH_ZERO);
        if (text_pos < idtdn_pkg::POS_DASH1)
          year_digits = year_digits * 14'd10 + 14'(dig);
        else if (text_pos < idtdn_pkg::POS_DASH2)
          month_digits = month_digits * 7'd10 + 7'(dig);
        else
          day_digits = day_digits * 7'd10 + 7'(dig);
      end
    end
    if (text_pos < idtdn_pkg::POS_SAT) text_pos = text_pos + 4'd1;
    if (last) begin
      ok = (text_pos == idtdn_pkg::DATE_LEN) && !layout_bad && month_digits >= 1 &&
           month_digits <= 12 && day_digits >= 1 &&
           day_digits <= days_in_month(year_digits, month_digits);
      res.ok  = ok;
      res.day = ok ? 23'(days_since_epoch(year_digits, month_digits, day_digits)) : '0;
      expected_dates = {expected_dates, res};
      text_pos     = '0;
      year_digits  = '0;
      month_digits = '0;
      day_digits   = '0;
      layout_bad   = 1'b0;
    end
  endtask

  // Input acceptance feeds the predictor; result acceptance is checked.
  always @(posedge clk) begin
    date_result_t want;
    in_taken  <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) begin
      parse_char(in_char_code, in_end_of_text);
      chars_taken++;
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_dates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d: no result expected, got valid=%0b day=%0d",
                   results_seen, out_date_valid, out_epoch_day);
      end else begin
        want = expected_dates.pop_front();
        if (out_date_valid !== want.ok || out_epoch_day !== want.day) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: expected valid=%0b day=%0d, got valid=%0b day=%0d",
                     results_seen, want.ok, want.day, out_date_valid, out_epoch_day);
        end
      end
    end
  end

  // Sender: each character word waits out its own gap before it is offered.
  always @(negedge clk) begin
    char_item_t item;
    logic       next_valid;
    if (rst_n && (!in_valid || in_taken)) begin
      next_valid = 1'b0;
      if (pending_chars.size() > 0 && !gap_loaded) begin
        gap_left   = pending_chars[0].gap;
        gap_loaded = 1'b1;
      end
      if (gap_loaded && gap_left == 0) begin
        item           = pending_chars.pop_front();
        gap_loaded     = 1'b0;
        in_char_code   <= item.code;
        in_end_of_text <= item.last;
        next_valid     = 1'b1;
      end else if (gap_loaded) begin
        gap_left--;
      end
      in_valid <= next_valid;
    end
  end

  // Receiver: a fresh stall after each result word, with calm stretches.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        if (rx_calm_left > 0) begin
          rx_calm_left--;
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 12);
          if ($urandom_range(0, 9) == 0) rx_calm_left = $urandom_range(4, 12);
        end
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0) && !hold_off;
    end
  end

  // One long hold-off on the result side so that the pipeline backs up.
  initial begin
    while (chars_taken < 300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic logic [15:0] digit_code(int v);
    return idtdn_pkg::CH_ZERO + 16'(v % 10);
  endfunction

  task automatic fill_date(input int y, input int m, input int d);
    text_buf = {};
    text_buf = {text_buf, digit_code(y / 1000)};
    text_buf = {text_buf, digit_code(y / 100)};
    text_buf = {text_buf, digit_code(y / 10)};
    text_buf = {text_buf, digit_code(y)};
    text_buf = {text_buf, idtdn_pkg::CH_DASH};
    text_buf = {text_buf, digit_code(m / 10)};
    text_buf = {text_buf, digit_code(m)};
    text_buf = {text_buf, idtdn_pkg::CH_DASH};
    text_buf = {text_buf, digit_code(d / 10)};
    text_buf = {text_buf, digit_code(d)};
  endtask

  task automatic fill_real_date();
    int y, m;
    y = ($urandom_range(0, 3) == 0) ? 100 * $urandom_range(0, 99) : $urandom_range(0, 9999);
    m = $urandom_range(idtdn_pkg::MON_JAN, idtdn_pkg::MON_DEC);
    fill_date(y, m, $urandom_range(1, days_in_month(y, m)));
  endtask

  task automatic queue_text();
    char_item_t item;
    bit         calm;
    calm = calm_left > 0;
    if (calm) calm_left--;
    else if ($urandom_range(0, 7) == 0) calm_left = $urandom_range(3, 8);
    foreach (text_buf[i]) begin
      item.code = text_buf[i];
      item.last = (i == text_buf.size() - 1);
      item.gap  = calm ? 0 : $urandom_range(0, 12);
      pending_chars = {pending_chars, item};
    end
  endtask

  function automatic logic [15:0] bad_code(bit dash_slot);
    case ($urandom_range(0, 4))
      0:       return dash_slot ? idtdn_pkg::CH_ZERO : idtdn_pkg::CH_ZERO - 16'd1;
      1:       return dash_slot ? idtdn_pkg::CH_NINE : idtdn_pkg::CH_NINE + 16'd1;
      2:       return dash_slot ? 16'h002E : idtdn_pkg::CH_DASH;
      3:       return 16'(idtdn_pkg::CH_ZERO | 16'h0100);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_text();
    int y, m, d, p, n, kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      fill_real_date();
    end else if (kind < 70) begin
      y = ($urandom_range(0, 1) == 0) ? 100 * $urandom_range(0, 99) : $urandom_range(0, 9999);
      m = $urandom_range(idtdn_pkg::MON_JAN, idtdn_pkg::MON_DEC);
      case ($urandom_range(0, 3))
        0: fill_date(y, m, days_in_month(y, m) + 1);
        1: fill_date(y, m, 0);
        2: fill_date(y, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(13, 99),
                     $urandom_range(0, 99));
        default: fill_date(y, idtdn_pkg::MON_FEB, 29);
      endcase
    end else if (kind < 80) begin
      fill_real_date();
      p = $urandom_range(idtdn_pkg::POS_YH0, idtdn_pkg::POS_DAY1);
      text_buf[p] = bad_code(p == idtdn_pkg::POS_DASH1 || p == idtdn_pkg::POS_DASH2);
    end else if (kind < 90) begin
      fill_real_date();
      if ($urandom_range(0, 1) == 0) begin
        n = $urandom_range(1, 9);
        while (text_buf.size() > n) void'(text_buf.pop_back());
      end else begin
        n = $urandom_range(1, 10);
        repeat (n)
          text_buf = {text_buf, ($urandom_range(0, 1) == 0) ? digit_code($urandom_range(0, 9))
                                                            : 16'($urandom)};
      end
    end else begin
      text_buf = {};
      n = $urandom_range(1, 14);
      repeat (n)
        case ($urandom_range(0, 2))
          0:       text_buf = {text_buf, digit_code($urandom_range(0, 9))};
          1:       text_buf = {text_buf, idtdn_pkg::CH_DASH};
          default: text_buf = {text_buf, 16'($urandom)};
        endcase
    end
    queue_text();
  endtask

  initial begin
    // Earliest and latest dates, a one-word text with every bit set, and a
    // short text of odd characters.
    fill_date(0, idtdn_pkg::MON_JAN, 1);
    queue_text();
    fill_date(9999, idtdn_pkg::MON_DEC, 31);
    queue_text();
    text_buf = {16'hFFFF};
    queue_text();
    text_buf = {16'h0000, idtdn_pkg::CH_DASH, 16'h8000};
    queue_text();
    while (pending_chars.size() < 650) random_text();
    total_chars = pending_chars.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (chars_taken < total_chars) @(posedge clk);
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
